### src/mm_pkg.sv
// Package with the shared types and codes of the matrix multiplier.
package mm_pkg;

  // Field widths fixed by the item format.
  localparam int unsigned IDX_W  = 3;
  localparam int unsigned DIM_W  = 4;
  localparam int unsigned ELEM_W = 16;
  localparam int unsigned PROD_W = 40;
  localparam int unsigned MUL_W  = 2 * ELEM_W;

  // Command codes carried in tuser.
  typedef enum logic [1:0] {
    CMD_LOAD_A  = 2'd0,
    CMD_LOAD_B  = 2'd1,
    CMD_COMPUTE = 2'd2,
    CMD_NONE    = 2'd3
  } mm_cmd_e;

  // Register indexes of the configuration port.
  typedef enum logic [1:0] {
    REG_ROWS_A    = 2'd0,
    REG_INNER_DIM = 2'd1,
    REG_COLS_B    = 2'd2,
    REG_NONE      = 2'd3
  } mm_reg_e;

  // One element of A travelling down the row of cells.
  typedef struct packed {
    logic                     valid;
    logic                     first;
    logic                     last_k;
    logic                     last_row;
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         k;
    logic signed [ELEM_W-1:0] a;
  } mm_tok_t;

  // Write of one element of B, broadcast to every cell.
  typedef struct packed {
    logic                     en;
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         col;
    logic signed [ELEM_W-1:0] data;
  } mm_bwr_t;

  // Finished element of C offered by a cell.
  typedef struct packed {
    logic                     valid;
    logic                     last;
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         col;
    logic signed [PROD_W-1:0] product;
  } mm_res_t;

endpackage

### src/matrix_multiply_top.sv
// Top level of the matrix multiplier: sequencer, store of A and the row of cells.
// A load item writes one in-range element of A or B; a compute item streams A row by row,
// each row padded to max(inner_dim, cols_b) slots, and puts its results in the output
// register. Input is held off until the last result is in the output register.
// Reset clears control state and sets all dimensions to 8; stores hold no defined data.
module matrix_multiply_top #(
  parameter int unsigned MAX_DIM = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // row[2:0], col[5:3], value[21:6], zero pad
  input  logic [1:0]  s_axis_tuser,   // cmd[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // out_row[2:0], out_col[5:3], product[45:6], zero pad
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_addr_i,
  input  logic [3:0]  cfg_data_i
);
  import mm_pkg::*;

  localparam int unsigned AW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int unsigned AD = 1 << (2 * AW);
  localparam logic [DIM_W-1:0] MAXD = DIM_W'(MAX_DIM);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN
  } state_e;

  state_e           state_q;
  logic [DIM_W-1:0] rows_a_q, inner_q, cols_b_q;
  logic [DIM_W-1:0] n_eff, m_eff, p_eff, s_eff;
  logic [IDX_W-1:0] r_q, slot_q;
  logic             en, in_acc;
  mm_cmd_e          cmd;
  logic [IDX_W-1:0] in_row, in_col;
  logic signed [ELEM_W-1:0] in_val;

  logic signed [ELEM_W-1:0] store_a [AD];
  logic signed [ELEM_W-1:0] a_rd_q;
  mm_tok_t          issue, meta_q;
  mm_tok_t          tok [MAX_DIM+1];
  mm_res_t          res [MAX_DIM];
  mm_res_t          sel;
  logic [MAX_DIM-1:0] res_vec;
  mm_bwr_t          bwr;

  logic             out_valid_q, out_last_q;
  logic [IDX_W-1:0] out_row_q, out_col_q;
  logic signed [PROD_W-1:0] out_prod_q;

  // Effective dimensions: zero acts as one, large values clamp to the maximum.
  function automatic logic [DIM_W-1:0] eff(input logic [DIM_W-1:0] v);
    if (v == '0) return DIM_W'(1);
    if (v > MAXD) return MAXD;
    return v;
  endfunction

  assign n_eff = eff(rows_a_q);
  assign m_eff = eff(inner_q);
  assign p_eff = eff(cols_b_q);
  assign s_eff = (m_eff > p_eff) ? m_eff : p_eff;

  // Input field unpacking.
  assign cmd    = mm_cmd_e'(s_axis_tuser);
  assign in_row = s_axis_tdata[2:0];
  assign in_col = s_axis_tdata[5:3];
  assign in_val = s_axis_tdata[21:6];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign en            = !out_valid_q || m_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_a_q <= DIM_W'(8);
      inner_q  <= DIM_W'(8);
      cols_b_q <= DIM_W'(8);
    end else if (cfg_valid_i) begin
      unique case (mm_reg_e'(cfg_addr_i))
        REG_ROWS_A:    rows_a_q <= cfg_data_i;
        REG_INNER_DIM: inner_q  <= cfg_data_i;
        REG_COLS_B:    cols_b_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Store of A: written by in-range loads, read once per cycle unless the output stalls.
  always_ff @(posedge clk_i) begin
    if (in_acc && (cmd == CMD_LOAD_A) &&
        (DIM_W'(in_row) < n_eff) && (DIM_W'(in_col) < m_eff)) begin
      store_a[{in_row[AW-1:0], in_col[AW-1:0]}] <= in_val;
    end
    if (en) begin
      a_rd_q <= store_a[{r_q[AW-1:0], slot_q[AW-1:0]}];
    end
  end

  // Loads of B go to the cell that holds the column.
  assign bwr.en   = in_acc && (cmd == CMD_LOAD_B) &&
                    (DIM_W'(in_row) < m_eff) && (DIM_W'(in_col) < p_eff);
  assign bwr.row  = in_row;
  assign bwr.col  = in_col;
  assign bwr.data = in_val;

  // Token issued for the current slot of the current row.
  assign issue.valid    = (state_q == ST_ISSUE) && (DIM_W'(slot_q) < m_eff);
  assign issue.first    = (slot_q == '0);
  assign issue.last_k   = (DIM_W'(slot_q) == m_eff - DIM_W'(1));
  assign issue.last_row = (DIM_W'(r_q) == n_eff - DIM_W'(1));
  assign issue.row      = r_q;
  assign issue.k        = slot_q;
  assign issue.a        = '0;

  // Sequencer state and the registered output item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      r_q         <= '0;
      slot_q      <= '0;
      meta_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc && (cmd == CMD_COMPUTE)) begin
            state_q <= ST_ISSUE;
            r_q     <= '0;
            slot_q  <= '0;
          end
        end
        ST_ISSUE: begin
          if (en) begin
            if (DIM_W'(slot_q) == s_eff - DIM_W'(1)) begin
              slot_q <= '0;
              if (issue.last_row) state_q <= ST_DRAIN;
              else r_q <= r_q + IDX_W'(1);
            end else begin
              slot_q <= slot_q + IDX_W'(1);
            end
          end
        end
        ST_DRAIN: begin
          if (en && sel.valid && sel.last) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
      if (en) begin
        meta_q      <= issue;
        out_valid_q <= sel.valid;
      end
    end
  end

  // Output payload.
  always_ff @(posedge clk_i) begin
    if (en && sel.valid) begin
      out_last_q <= sel.last;
      out_row_q  <= sel.row;
      out_col_q  <= sel.col;
      out_prod_q <= sel.product;
    end
  end

  // Head of the chain: token metadata joined with the element read from A.
  assign tok[0] = {meta_q[$bits(mm_tok_t)-1:ELEM_W], a_rd_q};

  // Row of cells, one per column of the result.
  for (genvar i = 0; i < MAX_DIM; i++) begin : g_cell
    mm_cell #(
      .COL    (i),
      .MAX_DIM(MAX_DIM)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .en_i  (en),
      .p_i   (p_eff),
      .bwr_i (bwr),
      .tok_i (tok[i]),
      .tok_o (tok[i+1]),
      .res_o (res[i])
    );
    assign res_vec[i] = res[i].valid;
  end

  // At most one cell finishes in any cycle; pick it.
  always_comb begin
    sel = '0;
    for (int i = 0; i < MAX_DIM; i++) begin
      if (res[i].valid) sel = res[i];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {2'b00, out_prod_q, out_col_q, out_row_q};

  // Cells never finish together, so results cannot collide.
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(res_vec)) else $error("two cells finished in one cycle");

  // A compute item starts issuing from the first row.
  a_compute_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (cmd == CMD_COMPUTE) |=> (state_q == ST_ISSUE) && (r_q == '0))
    else $error("compute did not start issuing");

  // The row counter stays within the effective row count while issuing.
  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ISSUE) |-> (DIM_W'(r_q) < n_eff))
    else $error("row counter out of range");

  // No token enters the chain while the block is idle.
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !issue.valid)
    else $error("token issued while idle");

endmodule

### src/mm_cell.sv
// One multiply-accumulate cell holding one column of B.
module mm_cell #(
  parameter int unsigned COL    = 0,
  parameter int unsigned MAX_DIM = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic [mm_pkg::DIM_W-1:0] p_i,
  input  mm_pkg::mm_bwr_t bwr_i,
  input  mm_pkg::mm_tok_t tok_i,
  output mm_pkg::mm_tok_t tok_o,
  output mm_pkg::mm_res_t res_o
);
  import mm_pkg::*;

  localparam int unsigned AW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

  logic signed [ELEM_W-1:0] bcol_q [MAX_DIM];
  logic signed [MUL_W-1:0]  mul;
  logic signed [PROD_W-1:0] acc_d, acc_q;
  mm_tok_t                  tok_q;
  logic                     res_valid_q, res_last_q;
  logic [IDX_W-1:0]         res_row_q;
  logic                     in_range;

  // Column store: written by loads of B that address this column.
  always_ff @(posedge clk_i) begin
    if (bwr_i.en && (bwr_i.col == IDX_W'(COL))) begin
      bcol_q[bwr_i.row[AW-1:0]] <= bwr_i.data;
    end
  end

  // Multiply the passing element of A by this column's entry and accumulate.
  assign mul      = tok_i.a * bcol_q[tok_i.k[AW-1:0]];
  assign acc_d    = (tok_i.first ? '0 : acc_q) + PROD_W'(mul);
  assign in_range = (DIM_W'(COL) < p_i);

  // Control: forwarded token and the result flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q       <= '0;
      res_valid_q <= 1'b0;
    end else if (en_i) begin
      tok_q       <= tok_i;
      res_valid_q <= tok_i.valid && tok_i.last_k && in_range;
    end
  end

  // Payload: accumulator and the coordinates of the finished element.
  always_ff @(posedge clk_i) begin
    if (en_i && tok_i.valid) begin
      acc_q      <= acc_d;
      res_row_q  <= tok_i.row;
      res_last_q <= tok_i.last_row && (DIM_W'(COL) == p_i - DIM_W'(1));
    end
  end

  assign tok_o         = tok_q;
  assign res_o.valid   = res_valid_q;
  assign res_o.last    = res_last_q;
  assign res_o.row     = res_row_q;
  assign res_o.col     = IDX_W'(COL);
  assign res_o.product = acc_q;

endmodule
